### rtl/core/svfn_pkg.sv
// ----------------------------------------------------------------------------
// svfn_pkg: shared types and constants of the service full name splitter
// Word layouts, character codes, part codes and the escape phase encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svfn_pkg;

  // Default sizing
  localparam int MAX_PART_BYTES_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int CAP_W              = 13;

  // Register reset value of every capacity
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;

  // Part codes
  localparam logic [1:0] PART_INSTANCE = 2'd0;
  localparam logic [1:0] PART_TYPE     = 2'd1;
  localparam logic [1:0] PART_DOMAIN   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_INSTANCE_CAP = 2'd0;
  localparam logic [1:0] REG_TYPE_CAP     = 2'd1;
  localparam logic [1:0] REG_DOMAIN_CAP   = 2'd2;

  // Escape phase: what is held after a backslash
  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_BSLASH,
    ESC_ONE_DIGIT,
    ESC_TWO_DIGITS
  } esc_phase_t;

  // Input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } svfn_in_t;

  // Result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] part;
    logic       is_status;
    logic       all_ok;
    logic       last_of_run;
  } svfn_out_t;

  // Capacity registers
  typedef struct packed {
    logic [CAP_W-1:0] instance_capacity;
    logic [CAP_W-1:0] type_capacity;
    logic [CAP_W-1:0] domain_capacity;
  } svfn_cfg_t;

  // Command from front to back: the bytes kept for one input word,
  // optionally followed by a status result
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic [1:0]      part;
    logic            status;
    logic            ok;
  } svfn_cmd_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } svfn_qstat_t;

  // ASCII digit of a decimal value 0..9
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return {4'h3, d};
  endfunction

endpackage

### rtl/core/svfn_front.sv
// ----------------------------------------------------------------------------
// svfn_front: accept and classify input words
// Tracks part, escape and held dot, checks part capacity and builds one
// command per word listing the bytes to emit and an optional status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svfn_front import svfn_pkg::*; #(
  parameter int MAX_PART_BYTES = MAX_PART_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  svfn_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  svfn_in_t    in_data,
  input  svfn_qstat_t qstat,
  output logic        push,
  output svfn_cmd_t   cmd
);

  localparam int FW = $clog2(MAX_PART_BYTES);
  localparam int CW = (FW + 1 > CAP_W) ? FW + 1 : CAP_W;
  localparam logic [CW-1:0] CAP_LIMIT = CW'(MAX_PART_BYTES);

  logic [1:0]    part_r, part_nxt;
  esc_phase_t    esc_r, esc_nxt;
  logic [3:0]    dig0_r, dig1_r;
  logic          dot_r, dot_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          fit_r, fit_nxt;
  logic          ended_r, ended_nxt;

  logic          accept;
  logic [7:0]    b;
  logic          fin;
  logic          is_digit;
  logic [3:0]    dval;
  logic [9:0]    esc_sum;
  logic [7:0]    esc_value;

  logic [3:0][7:0] flush;
  logic [2:0]      flen;
  logic [3:0][7:0] want;
  logic [2:0]      nwant;
  logic [1:0]      spart;
  logic [FW-1:0]   base;
  logic            status;
  logic            plain;
  logic            hop;

  logic              any_zero;
  logic [CAP_W-1:0]  cap_raw;
  logic [CW-1:0]     cap_ext, cap_eff, fill_ext, room;
  logic              no_room;
  logic [2:0]        nemit;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign fin      = in_data.end_of_string;
  assign is_digit = (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
  assign dval     = b[3:0];

  // Decode the two held digits and the current digit to the low byte of their value
  assign esc_sum   = 10'(dig0_r) * 10'd100 + 10'(dig1_r) * 10'd10 + 10'(dval);
  assign esc_value = esc_sum[7:0];

  // Escape phase next state
  always_comb begin
    esc_nxt = esc_r;
    if (fin) begin
      esc_nxt = ESC_NONE;
    end else if (!ended_r) begin
      if (dot_r || esc_r == ESC_NONE || !is_digit) begin
        esc_nxt = (b == CH_BSLASH) ? ESC_BSLASH : ESC_NONE;
      end else begin
        case (esc_r)
          ESC_BSLASH:    esc_nxt = ESC_ONE_DIGIT;
          ESC_ONE_DIGIT: esc_nxt = ESC_TWO_DIGITS;
          default:       esc_nxt = ESC_NONE;
        endcase
      end
    end
  end

  // Escape phase outputs: the literal bytes to replay on a broken escape
  always_comb begin
    flush[0] = CH_BSLASH;
    flush[1] = digit_char(dig0_r);
    flush[2] = digit_char(dig1_r);
    flush[3] = CH_NUL;
    case (esc_r)
      ESC_NONE:       flen = 3'd0;
      ESC_BSLASH:     flen = 3'd1;
      ESC_ONE_DIGIT:  flen = 3'd2;
      ESC_TWO_DIGITS: flen = 3'd3;
      default:        flen = 3'd0;
    endcase
  end

  // Classify the word: bytes wanted, their part and part/dot/end updates
  always_comb begin
    want      = flush;
    nwant     = 3'd0;
    spart     = part_r;
    base      = fill_r;
    status    = 1'b0;
    plain     = 1'b0;
    hop       = 1'b0;
    dot_nxt   = dot_r;
    ended_nxt = ended_r;
    if (fin) begin
      nwant     = flen;
      status    = 1'b1;
      dot_nxt   = 1'b0;
      ended_nxt = 1'b0;
    end else if (!ended_r) begin
      if (dot_r) begin
        dot_nxt = 1'b0;
        if (b == CH_USCORE) begin
          want[0] = CH_DOT;
          want[1] = CH_USCORE;
          nwant   = 3'd2;
        end else begin
          spart = PART_DOMAIN;
          base  = '0;
          plain = 1'b1;
        end
      end else if (esc_r != ESC_NONE) begin
        if (is_digit) begin
          if (esc_r == ESC_TWO_DIGITS) begin
            want[0] = esc_value;
            nwant   = 3'd1;
          end
        end else begin
          nwant = flen;
          plain = 1'b1;
        end
      end else begin
        plain = 1'b1;
      end
      if (plain) begin
        if (b == CH_NUL) begin
          ended_nxt = 1'b1;
        end else if (b == CH_BSLASH) begin
          hop = 1'b0;
        end else if (b == CH_DOT && spart == PART_INSTANCE) begin
          hop = 1'b1;
        end else if (b == CH_DOT && spart == PART_TYPE) begin
          dot_nxt = 1'b1;
        end else begin
          want[nwant[1:0]] = b;
          nwant            = nwant + 3'd1;
        end
      end
    end
  end

  // Capacity check: kept bytes are a prefix of the wanted ones
  assign any_zero = (cfg.instance_capacity == '0) || (cfg.type_capacity == '0) ||
                    (cfg.domain_capacity == '0);

  always_comb begin
    case (spart)
      PART_INSTANCE: cap_raw = cfg.instance_capacity;
      PART_TYPE:     cap_raw = cfg.type_capacity;
      default:       cap_raw = cfg.domain_capacity;
    endcase
  end

  assign cap_ext  = CW'(cap_raw);
  assign cap_eff  = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
  assign fill_ext = CW'(base);
  assign no_room  = any_zero || (fill_ext + CW'(1) >= cap_eff);
  assign room     = cap_eff - fill_ext - CW'(1);

  always_comb begin
    if (no_room) begin
      nemit = 3'd0;
    end else if (room < CW'(nwant)) begin
      nemit = room[2:0];
    end else begin
      nemit = nwant;
    end
  end

  // Part, fill and fit updates
  always_comb begin
    if (fin) begin
      part_nxt = PART_INSTANCE;
      fill_nxt = '0;
      fit_nxt  = 1'b1;
    end else begin
      part_nxt = hop ? PART_TYPE : spart;
      fill_nxt = hop ? '0 : base + FW'(nemit);
      fit_nxt  = fit_r && (nemit == nwant);
    end
  end

  // Command to the queue
  assign push = accept && (nemit != 3'd0 || status);

  always_comb begin
    cmd.bytes  = want;
    cmd.nbytes = nemit;
    cmd.part   = spart;
    cmd.status = status;
    cmd.ok     = fit_r && (nemit == nwant) && !any_zero;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r  <= PART_INSTANCE;
      esc_r   <= ESC_NONE;
      dot_r   <= 1'b0;
      fill_r  <= '0;
      fit_r   <= 1'b1;
      ended_r <= 1'b0;
    end else if (accept) begin
      part_r  <= part_nxt;
      esc_r   <= esc_nxt;
      dot_r   <= dot_nxt;
      fill_r  <= fill_nxt;
      fit_r   <= fit_nxt;
      ended_r <= ended_nxt;
    end
  end

  // Held digits: capture while an escape collects them
  always_ff @(posedge clk) begin
    if (accept && !fin && !ended_r && !dot_r && is_digit) begin
      if (esc_r == ESC_BSLASH) begin
        dig0_r <= dval;
      end
      if (esc_r == ESC_ONE_DIGIT) begin
        dig1_r <= dval;
      end
    end
  end

endmodule

### rtl/core/svfn_queue.sv
// ----------------------------------------------------------------------------
// svfn_queue: command queue between front and back
// Small circular buffer of commands with an occupancy count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svfn_queue import svfn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  svfn_cmd_t   push_cmd,
  input  logic        pop,
  output svfn_cmd_t   head,
  output svfn_qstat_t qstat
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  svfn_cmd_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;

  assign head        = mem[rd_ptr_r];
  assign qstat.full  = (count_r == CNTW'(DEPTH));
  assign qstat.empty = (count_r == '0);

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

endmodule

### rtl/core/svfn_back.sv
// ----------------------------------------------------------------------------
// svfn_back: turn queued commands into result words
// Steps through the bytes of the head command, then its status, one result
// word per cycle into the output register while out_ready allows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svfn_back import svfn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  svfn_cmd_t   head,
  input  svfn_qstat_t qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output svfn_out_t   out_data
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  svfn_out_t  out_data_r;
  svfn_out_t  entry;
  logic [2:0] total;
  logic       last;
  logic       load;
  logic       take;

  assign load  = !out_valid_r || out_ready;
  assign take  = load && !qstat.empty;
  assign total = head.nbytes + 3'(head.status);
  assign last  = (3'(idx_r) + 3'd1 == total);
  assign pop   = take && last;

  // Select the byte at the index, or the status after the bytes
  always_comb begin
    if (3'(idx_r) < head.nbytes) begin
      entry.out_byte  = head.bytes[idx_r];
      entry.part      = head.part;
      entry.is_status = 1'b0;
      entry.all_ok    = 1'b0;
    end else begin
      entry.out_byte  = CH_NUL;
      entry.part      = PART_INSTANCE;
      entry.is_status = 1'b1;
      entry.all_ok    = head.ok;
    end
    entry.last_of_run = last;
  end

  // Output register and word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= !qstat.empty;
      end
      if (take) begin
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= entry;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/service_full_name_splitter_top.sv
// ----------------------------------------------------------------------------
// service_full_name_splitter_top: split a service full name into parts
// The first result word of an input word passes from the command queue to
//   the output register.
// Throughput: one input word per cycle while each word gives at most one
//   result and out_ready is high; a word with several results holds the output
//   register for each, and a four-entry command queue absorbs the difference.
// Reset: synchronous, active low; clears part state, queue and output, and
//   sets all capacities to 256. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module service_full_name_splitter_top import svfn_pkg::*; #(
  parameter int MAX_PART_BYTES = MAX_PART_BYTES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  svfn_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output svfn_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CAP_W-1:0] cfg_data
);

  svfn_cfg_t   cfg_r;
  svfn_qstat_t qstat;
  svfn_cmd_t   push_cmd;
  svfn_cmd_t   head;
  logic        push;
  logic        pop;

  // Capacity registers: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.instance_capacity <= CAP_RESET;
      cfg_r.type_capacity     <= CAP_RESET;
      cfg_r.domain_capacity   <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INSTANCE_CAP: cfg_r.instance_capacity <= cfg_data;
        REG_TYPE_CAP:     cfg_r.type_capacity     <= cfg_data;
        REG_DOMAIN_CAP:   cfg_r.domain_capacity   <= cfg_data;
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  svfn_front #(
    .MAX_PART_BYTES(MAX_PART_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .cmd      (push_cmd)
  );

  svfn_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  svfn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A full queue means the back end has a word waiting
  a_full_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("queue full with empty output register");

  // Status words carry a zero byte and close their run
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_status |->
      out_data.out_byte == CH_NUL && out_data.part == PART_INSTANCE &&
      out_data.last_of_run)
    else $error("malformed status word");

  // Byte words never report ok and name a real part
  a_byte_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_status |->
      !out_data.all_ok && out_data.part != 2'd3)
    else $error("malformed byte word");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
